@@ design/dmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants for the fixed-point dense matrix multiplier.
// ----------------------------------------------------------------------------
package dmm_pkg;

  // Default for the largest matrix dimension held in the element stores.
  localparam int MAX_DIM_DEF = 16;

  // Field widths fixed by the item formats.
  localparam int IDX_W   = 4;   // row and column index fields
  localparam int DIM_W   = 5;   // dimension registers
  localparam int VAL_W   = 16;  // Q8.8 element
  localparam int PROD_W  = 32;  // Q16.16 product
  localparam int RES_W   = 32;  // Q16.16 result
  localparam int ACC_W   = 36;  // exact sum of up to sixteen products
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd2;

  // Dimension register value after reset.
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  // Saturation limits of the result.
  localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

  // Request item.
  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] elem_value;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [RES_W-1:0] out_value;
    logic                    saturated;
    logic                    last;
  } rsp_t;

  // Control that travels with each operand pair into the MAC unit.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ design/dmm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dmm_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_mac
// Shared multiply-accumulate unit: one registered 16x16 product per cycle,
// an exact 36-bit accumulator and saturation of the finished sum.
// ----------------------------------------------------------------------------
module dmm_mac
  import dmm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic signed [RES_W-1:0] sum,
  output logic                    sat,
  output logic                    done
);

  mac_ctl_t                 prod_ctl;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-RES_W:0]     acc_top;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
    prod <= a * b;
  end

  // Accumulate stage; the first product of a dot product restarts the sum.
  always_comb begin
    acc_next = (prod_ctl.first ? '0 : acc)
             + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_ctl.valid & prod_ctl.last;
    end
    if (prod_ctl.valid) begin
      acc <= acc_next;
    end
  end

  // The sum fits in 32 bits when its upper bits are all sign copies.
  assign acc_top = acc[ACC_W-1:RES_W-1];
  assign sat     = !((&acc_top) || !(|acc_top));

  always_comb begin
    if (!sat) begin
      sum = acc[RES_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sum = RES_MIN;
    end else begin
      sum = RES_MAX;
    end
  end

endmodule

@@ design/dense_matrix_multiply.sv @@
`timescale 1ns / 1ps
// A load item writes the element store directly; a compute item emits one result
// per column, after k reads and MACs for that column plus the RAM read, multiply and
// accumulate stages of the shared MAC unit and the output register, which can stall.
// Throughput: one item at a time; req_ready is low while a row is computed.
// Reset clears control and sets the dimension registers to 16; the element
// stores are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// Fixed-point matrix multiply C = A * B over on-chip element stores, one
// product row per compute item, using a single shared MAC unit.
// ----------------------------------------------------------------------------
module dense_matrix_multiply
  import dmm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIM    = (MAX_DIM < 16) ? MAX_DIM : 16;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [DIM_W-1:0]        rows_m, inner_k, cols_n;
  logic [IDX_W-1:0]        cur_row, cur_row_next;
  logic [DIM_W-1:0]        k_eff, k_eff_next;
  logic [DIM_W-1:0]        n_eff, n_eff_next;
  logic [IDX_W-1:0]        t_cnt, t_cnt_next;
  logic [IDX_W-1:0]        j_cnt, j_cnt_next;
  mac_ctl_t                rd_ctl, rd_ctl_next;
  logic                    rsp_load;
  logic                    req_fire;
  logic                    load_in_range;
  logic                    we_a, we_b;
  logic [ADDR_W-1:0]       waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0]        rdata_a, rdata_b;
  logic signed [RES_W-1:0] mac_sum;
  logic                    mac_sat;
  logic                    mac_done;
  logic                    col_last;

  // A zero dimension acts as one, and a large one as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(LIM)) begin
      r = DIM_W'(LIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Store address of an element: row * MAX_DIM + column.
  function automatic logic [ADDR_W-1:0] make_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM)) + ADDR_W'(c);
  endfunction

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= DIM_RESET;
      inner_k <= DIM_RESET;
      cols_n  <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_M:  rows_m  <= cfg_data;
        REG_INNER_K: inner_k <= cfg_data;
        REG_COLS_N:  cols_n  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Element loads write straight into the stores.
  assign req_ready     = (state == ST_IDLE);
  assign req_fire      = req_valid && req_ready;
  assign load_in_range = (DIM_W'(req.row_index) < DIM_W'(LIM))
                      && (DIM_W'(req.col_index) < DIM_W'(LIM));
  assign we_a  = req_fire && (req.opcode == OP_LOAD_A) && load_in_range;
  assign we_b  = req_fire && (req.opcode == OP_LOAD_B) && load_in_range;
  assign waddr = make_addr(req.row_index, req.col_index);

  // Operand addresses: A walks along the row, B walks down the column.
  assign raddr_a = make_addr(cur_row, t_cnt);
  assign raddr_b = make_addr(t_cnt, j_cnt);

  dmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (req.elem_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  dmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (req.elem_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  dmm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .a    (rdata_a),
    .b    (rdata_b),
    .sum  (mac_sum),
    .sat  (mac_sat),
    .done (mac_done)
  );

  assign col_last = ({1'b0, j_cnt} == n_eff - DIM_W'(1));
  assign rsp_load = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  // Sequencer: issue k operand reads per column, wait for the sum, emit it.
  always_comb begin
    state_next   = state;
    cur_row_next = cur_row;
    k_eff_next   = k_eff;
    n_eff_next   = n_eff;
    t_cnt_next   = t_cnt;
    j_cnt_next   = j_cnt;
    rd_ctl_next  = '0;
    case (state)
      ST_IDLE: begin
        if (req_fire && (req.opcode == OP_COMPUTE)
            && (DIM_W'(req.row_index) < eff_dim(rows_m))) begin
          cur_row_next = req.row_index;
          k_eff_next   = eff_dim(inner_k);
          n_eff_next   = eff_dim(cols_n);
          t_cnt_next   = '0;
          j_cnt_next   = '0;
          state_next   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_ctl_next.valid = 1'b1;
        rd_ctl_next.first = (t_cnt == '0);
        rd_ctl_next.last  = ({1'b0, t_cnt} == k_eff - DIM_W'(1));
        if (rd_ctl_next.last) begin
          t_cnt_next = '0;
          state_next = ST_WAIT;
        end else begin
          t_cnt_next = t_cnt + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rsp_load) begin
          if (col_last) begin
            state_next = ST_IDLE;
          end else begin
            j_cnt_next = j_cnt + IDX_W'(1);
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_ctl <= '0;
    end else begin
      state  <= state_next;
      rd_ctl <= rd_ctl_next;
    end
    cur_row <= cur_row_next;
    k_eff   <= k_eff_next;
    n_eff   <= n_eff_next;
    t_cnt   <= t_cnt_next;
    j_cnt   <= j_cnt_next;
  end

  // Output register: holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      rsp.out_row   <= cur_row;
      rsp.out_col   <= j_cnt;
      rsp.out_value <= mac_sum;
      rsp.saturated <= mac_sat;
      rsp.last      <= col_last;
    end
  end

  // A finished sum only arrives while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_WAIT))
    else $error("MAC sum finished outside the wait state");

  // A clamped result carries one of the two limit values.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.saturated) |-> (rsp.out_value == RES_MAX || rsp.out_value == RES_MIN))
    else $error("saturated result is not a limit value");

  // A new result is loaded only after the previous one has been taken.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("waiting result item was overwritten");

endmodule
